/* rtl/battery_level_trimmed_mean_hysteresis_macros.svh */
// assertion macros for the battery level detector rtl
// no dependencies; included inside module bodies
`ifndef BATTERY_LEVEL_TRIMMED_MEAN_HYSTERESIS_MACROS_SVH
`define BATTERY_LEVEL_TRIMMED_MEAN_HYSTERESIS_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define BTLVL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define BTLVL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/btlvl_pkg.sv */
// shared types, constants and level thresholds of the battery level detector
// no dependencies
`default_nettype none

package btlvl_pkg;

    // batch size and field widths
    localparam int SAMPLES   = 10;
    localparam int SAMPLE_W  = 10;
    localparam int SUM_W     = 14;
    localparam int CNT_W     = 4;
    localparam int FS_W      = 12;
    localparam int VOLT_W    = 12;
    localparam int LEVEL_W   = 2;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;
    localparam logic [FS_W-1:0]     FS_RESET   = FS_W'(3600);
    localparam logic [CNT_W-1:0]    LAST_CNT   = CNT_W'(SAMPLES - 1);

    // converter full code
    localparam int FULL_CODE = 1024;

    // serial multiplier: one multiplier bit per cycle
    localparam int PROD_W    = FS_W + SUM_W;
    localparam int MUL_STEPS = SUM_W;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS);

    // serial divider: one quotient bit per cycle, divisor folds both divisions
    localparam int DIVISOR   = (SAMPLES - 2) * FULL_CODE;
    localparam int REM_W     = $clog2(DIVISOR) + 1;
    localparam int DIV_STEPS = PROD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // plain thresholds for the first batch
    localparam logic [VOLT_W-1:0] TH_FIRST_3 = VOLT_W'(2900);
    localparam logic [VOLT_W-1:0] TH_FIRST_2 = VOLT_W'(2800);
    localparam logic [VOLT_W-1:0] TH_FIRST_1 = VOLT_W'(2700);

    // hysteresis bands for later batches
    localparam logic [VOLT_W-1:0] TH_UP_3   = VOLT_W'(2920);
    localparam logic [VOLT_W-1:0] TH_HI_2   = VOLT_W'(2880);
    localparam logic [VOLT_W-1:0] TH_LO_2   = VOLT_W'(2820);
    localparam logic [VOLT_W-1:0] TH_HI_1   = VOLT_W'(2780);
    localparam logic [VOLT_W-1:0] TH_LO_1   = VOLT_W'(2720);
    localparam logic [VOLT_W-1:0] TH_DOWN_0 = VOLT_W'(2680);

    typedef enum logic [LEVEL_W-1:0] {
        LVL_EMPTY = 2'd0,
        LVL_LOW   = 2'd1,
        LVL_MID   = 2'd2,
        LVL_FULL  = 2'd3
    } t_level;

    typedef enum logic [2:0] {
        S_COLLECT,
        S_LOAD,
        S_MUL,
        S_DIV,
        S_LEVEL
    } t_state;

    // status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_status;

endpackage

`default_nettype wire

/* rtl/btlvl_accum.sv */
// batch accumulator: running sum, smallest and largest sample, sample count
// depends on btlvl_pkg
`default_nettype none

module btlvl_accum (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_take,
    input  wire  [btlvl_pkg::SAMPLE_W-1:0]   i_sample,
    input  wire                              i_clear,
    output logic                             o_last,
    output logic [btlvl_pkg::SUM_W-1:0]      o_trimmed
);
    import btlvl_pkg::*;

    logic [SUM_W-1:0]    r_sum;
    logic [SAMPLE_W-1:0] r_min;
    logic [SAMPLE_W-1:0] r_max;
    logic [CNT_W-1:0]    r_cnt;

    // this word closes the batch
    assign o_last = (r_cnt == LAST_CNT);

    // extremes come back out once the batch is complete
    assign o_trimmed = r_sum - SUM_W'(r_min) - SUM_W'(r_max);

    // accumulate one word per cycle while i_take is high, back to empty after the batch is used
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_sum <= '0;
            r_min <= SAMPLE_MAX;
            r_max <= '0;
            r_cnt <= '0;
        end else if (i_take) begin
            r_sum <= r_sum + SUM_W'(i_sample);
            if (i_sample < r_min) begin
                r_min <= i_sample;
            end
            if (i_sample > r_max) begin
                r_max <= i_sample;
            end
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

endmodule

`default_nettype wire

/* rtl/btlvl_ser_mul.sv */
// bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on btlvl_pkg
`default_nettype none

module btlvl_ser_mul (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_load,
    input  wire  [btlvl_pkg::FS_W-1:0]       i_multiplicand,
    input  wire  [btlvl_pkg::SUM_W-1:0]      i_multiplier,
    output btlvl_pkg::t_unit_status          o_status,
    output logic [btlvl_pkg::PROD_W-1:0]     o_product
);
    import btlvl_pkg::*;

    logic [FS_W-1:0]      r_mcand;
    logic [FS_W-1:0]      r_hi;
    logic [SUM_W-1:0]     r_lo;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [FS_W:0]        partial;

    // add the multiplicand when the current multiplier bit is set
    assign partial = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mcand} : '0);

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_product     = {r_hi, r_lo};

    // control: step count and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_load) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + MUL_CNT_W'(1);
                if (r_cnt == MUL_CNT_W'(MUL_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // product shift register, high half takes the sum
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mcand <= i_multiplicand;
            r_hi    <= '0;
            r_lo    <= i_multiplier;
        end else if (r_busy) begin
            r_hi <= partial[FS_W:1];
            r_lo <= {partial[0], r_lo[SUM_W-1:1]};
        end
    end

endmodule

`default_nettype wire

/* rtl/btlvl_ser_div.sv */
// bit-serial restoring divider by the fixed batch divisor, one quotient bit per cycle
// depends on btlvl_pkg
`default_nettype none

module btlvl_ser_div (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_load,
    input  wire  [btlvl_pkg::PROD_W-1:0]     i_dividend,
    output btlvl_pkg::t_unit_status          o_status,
    output logic [btlvl_pkg::VOLT_W-1:0]     o_quotient
);
    import btlvl_pkg::*;

    localparam logic [REM_W-1:0] DIV_VAL = REM_W'(DIVISOR);

    logic [PROD_W-1:0]    r_num;
    logic [REM_W-1:0]     r_rem;
    logic [VOLT_W-1:0]    r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [REM_W-1:0]     trial;
    logic                 fits;

    // bring down the next dividend bit and test against the divisor
    assign trial = {r_rem[REM_W-2:0], r_num[PROD_W-1]};
    assign fits  = (trial >= DIV_VAL);

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quotient    = r_quo;

    // control: step count and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_load) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift registers; upper quotient bits fall off
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_num <= i_dividend;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[PROD_W-2:0], 1'b0};
            r_rem <= fits ? (trial - DIV_VAL) : trial;
            r_quo <= {r_quo[VOLT_W-2:0], fits};
        end
    end

endmodule

`default_nettype wire

/* rtl/battery_level_trimmed_mean_hysteresis.sv */
// battery level detector: trimmed batch mean scaled to millivolts, hysteresis level
// non-final words of a batch are taken one per cycle; after the final word busy is high
// through load, serial multiply, handoff, serial divide, handoff and classify
// the result strobe is high for one cycle right after busy falls; the receiver cannot stall
// synchronous active-low reset: empty batch, level 0, first-batch thresholds, scale 3600 mV
`default_nettype none

module battery_level_trimmed_mean_hysteresis (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               start,
    output logic                              busy,
    input  wire  [btlvl_pkg::SAMPLE_W-1:0]    i_sample,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [btlvl_pkg::FS_W-1:0]        i_cfg_data,
    output logic                              o_strobe,
    output logic [btlvl_pkg::LEVEL_W-1:0]     o_battery_level,
    output logic [btlvl_pkg::VOLT_W-1:0]      o_voltage_mv,
    output logic                              o_level_changed
);
    import btlvl_pkg::*;

`include "battery_level_trimmed_mean_hysteresis_macros.svh"

    t_state             r_state;
    t_state             n_state;
    logic [FS_W-1:0]    r_full_scale;
    t_level             r_held_level;
    t_level             n_level;
    logic               n_changed;
    logic               r_first_done;
    logic               r_strobe;
    logic [VOLT_W-1:0]  r_volt;
    logic               r_changed;

    logic               accept;
    logic               acc_last;
    logic               acc_clear;
    logic [SUM_W-1:0]   trimmed;
    logic               mul_load;
    t_unit_status       mul_status;
    logic [PROD_W-1:0]  product;
    t_unit_status       div_status;
    logic [VOLT_W-1:0]  volt;

    assign busy        = (r_state != S_COLLECT);
    assign accept      = start && !busy;
    assign o_cfg_ready = !busy;

    // batch accumulation
    btlvl_accum u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (accept),
        .i_sample  (i_sample),
        .i_clear   (acc_clear),
        .o_last    (acc_last),
        .o_trimmed (trimmed)
    );

    // full_scale times trimmed sum
    btlvl_ser_mul u_mul (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (mul_load),
        .i_multiplicand (r_full_scale),
        .i_multiplier   (trimmed),
        .o_status       (mul_status),
        .o_product      (product)
    );

    // divide by trimmed count and full code in one pass
    btlvl_ser_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (mul_status.done),
        .i_dividend (product),
        .o_status   (div_status),
        .o_quotient (volt)
    );

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer next state and unit controls
    always_comb begin
        n_state   = r_state;
        mul_load  = 1'b0;
        acc_clear = 1'b0;
        unique case (r_state)
            S_COLLECT: begin
                if (accept && acc_last) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                mul_load  = 1'b1;
                acc_clear = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                if (mul_status.done) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_status.done) begin
                    n_state = S_LEVEL;
                end
            end
            S_LEVEL: begin
                n_state = S_COLLECT;
            end
            default: begin
                n_state = S_COLLECT;
            end
        endcase
    end

    // level decision: plain thresholds first, hysteresis bands after
    always_comb begin
        n_level   = r_held_level;
        n_changed = 1'b1;
        if (!r_first_done) begin
            priority if (volt >= TH_FIRST_3) begin
                n_level = LVL_FULL;
            end else if (volt >= TH_FIRST_2) begin
                n_level = LVL_MID;
            end else if (volt >= TH_FIRST_1) begin
                n_level = LVL_LOW;
            end else begin
                n_level = LVL_EMPTY;
            end
        end else begin
            priority if (volt > TH_UP_3) begin
                n_level = LVL_FULL;
            end else if (volt > TH_LO_2 && volt < TH_HI_2) begin
                n_level = LVL_MID;
            end else if (volt > TH_LO_1 && volt < TH_HI_1) begin
                n_level = LVL_LOW;
            end else if (volt < TH_DOWN_0) begin
                n_level = LVL_EMPTY;
            end else begin
                n_changed = 1'b0;
            end
        end
    end

    // scale register, level state and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_scale <= FS_RESET;
            r_held_level <= LVL_EMPTY;
            r_first_done <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_full_scale <= i_cfg_data;
            end
            r_strobe <= (r_state == S_LEVEL);
            if (r_state == S_LEVEL) begin
                r_held_level <= n_level;
                r_first_done <= 1'b1;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_LEVEL) begin
            r_volt    <= volt;
            r_changed <= n_changed;
        end
    end

    assign o_strobe        = r_strobe;
    assign o_battery_level = r_held_level;
    assign o_voltage_mv    = r_volt;
    assign o_level_changed = r_changed;

    // checks
    `BTLVL_ASSERT_NOW(a_strobe_when_idle, i_clk, i_rst_n, o_strobe, !busy, "strobe while busy")
    `BTLVL_ASSERT_NEXT(a_last_word_busy, i_clk, i_rst_n, accept && acc_last, busy, "no busy")
    `BTLVL_ASSERT_NEXT(a_level_strobes, i_clk, i_rst_n, r_state == S_LEVEL, o_strobe, "missing strobe")
    `BTLVL_ASSERT_NOW(a_units_exclusive, i_clk, i_rst_n, mul_status.busy, !div_status.busy, "units overlap")

endmodule

`default_nettype wire

/* bench/battery_level_trimmed_mean_hysteresis_test.sv */
`timescale 1ns / 1ps
// testbench for the battery level detector: feeds sample batches, checks each level reading
// depends on btlvl_pkg and battery_level_trimmed_mean_hysteresis

module battery_level_trimmed_mean_hysteresis_test;
    import btlvl_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int TAIL_CYCLES = 60;
    localparam int TRIM_CNT    = SAMPLES - 2;
    localparam int SUM_CAP     = TRIM_CNT * 1023;

    typedef struct packed {
        t_level              level;
        logic [VOLT_W-1:0]   mv;
        logic                changed;
    } t_reading;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   start       = 1'b0;
    logic                   busy;
    logic [SAMPLE_W-1:0]    i_sample    = '0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [FS_W-1:0]        i_cfg_data  = '0;
    logic                   o_strobe;
    logic [LEVEL_W-1:0]     o_battery_level;
    logic [VOLT_W-1:0]      o_voltage_mv;
    logic                   o_level_changed;

    battery_level_trimmed_mean_hysteresis uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_sample        (i_sample),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_strobe        (o_strobe),
        .o_battery_level (o_battery_level),
        .o_voltage_mv    (o_voltage_mv),
        .o_level_changed (o_level_changed)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // detector state as the bench sees it
    logic [FS_W-1:0]     scale_mv   = FS_RESET;
    logic [SUM_W-1:0]    batch_sum  = '0;
    logic [SAMPLE_W-1:0] batch_min  = SAMPLE_MAX;
    logic [SAMPLE_W-1:0] batch_max  = '0;
    logic [CNT_W-1:0]    batch_cnt  = '0;
    logic                first_done = 1'b0;
    t_level              level_q    = LVL_EMPTY;
    t_reading            expected_readings[$];

    logic [SAMPLE_W-1:0] batch_words [SAMPLES];
    int errors           = 0;
    int words_sent       = 0;
    int batches_sent     = 0;
    int readings_checked = 0;
    int scale_writes     = 0;
    int cycle_count      = 0;

    // fold one accepted word into the batch; a full batch yields a level reading
    function automatic void predict_level_reading(input logic [SAMPLE_W-1:0] s);
        logic [SUM_W-1:0] trimmed;
        longint unsigned  scaled;
        t_reading         r;
        batch_sum = batch_sum + SUM_W'(s);
        if (s < batch_min) batch_min = s;
        if (s > batch_max) batch_max = s;
        batch_cnt = batch_cnt + CNT_W'(1);
        if (batch_cnt != 0 && batch_cnt < SAMPLES) return;

        // drop one smallest and one largest, scale the mean to millivolts
        trimmed = batch_sum - SUM_W'(batch_min) - SUM_W'(batch_max);
        scaled  = 64'(scale_mv);
        scaled  = scaled * 64'(trimmed) / TRIM_CNT / FULL_CODE;
        r.mv      = scaled[VOLT_W-1:0];
        r.changed = 1'b1;

        if (!first_done) begin
            // plain thresholds on the first batch after reset
            if (r.mv >= TH_FIRST_3)      level_q = LVL_FULL;
            else if (r.mv >= TH_FIRST_2) level_q = LVL_MID;
            else if (r.mv >= TH_FIRST_1) level_q = LVL_LOW;
            else                         level_q = LVL_EMPTY;
            first_done = 1'b1;
        end else begin
            // hysteresis bands, level held in the gaps
            if (r.mv > TH_UP_3)                            level_q = LVL_FULL;
            else if (r.mv > TH_LO_2 && r.mv < TH_HI_2)     level_q = LVL_MID;
            else if (r.mv > TH_LO_1 && r.mv < TH_HI_1)     level_q = LVL_LOW;
            else if (r.mv < TH_DOWN_0)                     level_q = LVL_EMPTY;
            else                                           r.changed = 1'b0;
        end
        r.level = level_q;

        batch_sum = '0;
        batch_min = SAMPLE_MAX;
        batch_max = '0;
        batch_cnt = '0;
        expected_readings.push_back(r);
    endfunction

    // compare every strobed reading against the oldest expected one
    always @(posedge i_clk) begin : check_readings
        t_reading want;
        if (i_rst_n && o_strobe) begin
            if (expected_readings.size() == 0) begin
                $error("unexpected reading: level %0d, voltage_mv %0d, level_changed %0d",
                       o_battery_level, o_voltage_mv, o_level_changed);
                errors++;
            end else begin
                want = expected_readings.pop_front();
                readings_checked++;
                if (o_battery_level !== want.level) begin
                    $error("battery_level: expected %0d, got %0d", want.level,
                           o_battery_level);
                    errors++;
                end
                if (o_voltage_mv !== want.mv) begin
                    $error("voltage_mv: expected %0d, got %0d", want.mv, o_voltage_mv);
                    errors++;
                end
                if (o_level_changed !== want.changed) begin
                    $error("level_changed: expected %0d, got %0d", want.changed,
                           o_level_changed);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("battery_level_trimmed_mean_hysteresis_test: errors");
            $finish;
        end
    end

    // one sample word; start stays high so back-to-back words need no gap
    task automatic send_word(input logic [SAMPLE_W-1:0] s);
        start    <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (busy);
        predict_level_reading(s);
        words_sent++;
    endtask

    // sender idle burst, with junk on the sample lines
    task automatic pause_sender(input int n);
        start    <= 1'b0;
        i_sample <= SAMPLE_W'($urandom);
        repeat (n) @(posedge i_clk);
    endtask

    // hold off until every expected reading has come and the block is idle
    task automatic wait_drained();
        start <= 1'b0;
        while (expected_readings.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_full_scale(input logic [FS_W-1:0] mv);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mv;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        scale_mv = mv;
        scale_writes++;
    endtask

    task automatic send_batch(input bit gaps);
        for (int k = 0; k < SAMPLES; k++) begin
            if (gaps && $urandom_range(3, 0) == 0) pause_sender($urandom_range(18, 1));
            send_word(batch_words[k]);
        end
        batches_sent++;
    endtask

    task automatic fill_batch(input logic [SAMPLE_W-1:0] s);
        for (int k = 0; k < SAMPLES; k++) batch_words[k] = s;
    endtask

    task automatic shuffle_batch();
        int                  j;
        logic [SAMPLE_W-1:0] tmp;
        for (int k = SAMPLES - 1; k > 0; k--) begin
            j = $urandom_range(k, 0);
            tmp = batch_words[k];
            batch_words[k] = batch_words[j];
            batch_words[j] = tmp;
        end
    endtask

    // batch whose trimmed mean lands on the given millivolt value at the current scale
    task automatic build_batch_for(input int target_mv);
        int need;
        int base;
        int extra;
        int top;
        if (scale_mv == 0) need = $urandom_range(SUM_CAP, 0);
        else need = (target_mv * FULL_CODE * TRIM_CNT + int'(scale_mv) - 1) / int'(scale_mv);
        if (need > SUM_CAP) need = SUM_CAP;
        if (need < 0) need = 0;
        base  = need / TRIM_CNT;
        extra = need % TRIM_CNT;
        top   = (extra != 0) ? base + 1 : base;
        for (int k = 0; k < TRIM_CNT; k++)
            batch_words[k] = SAMPLE_W'((k < extra) ? base + 1 : base);
        // outliers that bracket the kept words, ties allowed
        batch_words[TRIM_CNT]     = SAMPLE_W'($urandom_range(base, 0));
        batch_words[TRIM_CNT + 1] = SAMPLE_W'($urandom_range(1023, top));
        shuffle_batch();
    endtask

    // uniform, clustered or constant batches
    task automatic build_random_batch();
        int mode;
        int center;
        int spread;
        int v;
        mode   = $urandom_range(2, 0);
        center = $urandom_range(1023, 0);
        spread = $urandom_range(60, 0);
        for (int k = 0; k < SAMPLES; k++) begin
            case (mode)
                0: v = $urandom_range(1023, 0);
                1: v = center + $urandom_range(2 * spread, 0) - spread;
                default: v = center;
            endcase
            if (v < 0) v = 0;
            if (v > 1023) v = 1023;
            batch_words[k] = SAMPLE_W'(v);
        end
    endtask

    // target near a band edge, sometimes anywhere in the interesting range
    function automatic int pick_band_target();
        int band_edges [6];
        band_edges = '{int'(TH_DOWN_0), int'(TH_LO_1), int'(TH_HI_1),
                       int'(TH_LO_2), int'(TH_HI_2), int'(TH_UP_3)};
        if ($urandom_range(3, 0) == 0) return $urandom_range(3000, 2600);
        return band_edges[$urandom_range(5, 0)] + $urandom_range(6, 0) - 3;
    endfunction

    // first batch lands exactly on the top plain threshold
    task automatic test_first_batch_threshold();
        build_batch_for(int'(TH_FIRST_3));
        send_batch(1'b0);
        wait_drained();
    endtask

    // all-ones batch with the scale raised mid-batch, then an all-zero batch
    task automatic test_full_code_and_midbatch_scale();
        fill_batch(SAMPLE_MAX);
        for (int k = 0; k < SAMPLES / 2; k++) send_word(batch_words[k]);
        wait_drained();
        write_full_scale('1);
        for (int k = SAMPLES / 2; k < SAMPLES; k++) send_word(batch_words[k]);
        batches_sent++;
        fill_batch('0);
        send_batch(1'b1);
        wait_drained();
    endtask

    // batches steered around the hysteresis edges, scale changed every few batches
    task automatic test_hysteresis_bands(input int batches);
        for (int b = 0; b < batches; b++) begin
            if (b % 8 == 0) begin
                wait_drained();
                write_full_scale((b == 0) ? FS_RESET : FS_W'($urandom_range(4095, 2950)));
            end
            build_batch_for(pick_band_target());
            send_batch(1'($urandom_range(1, 0)));
        end
    endtask

    // unconstrained sample batches across scale extremes
    task automatic test_random_batches(input int batches);
        for (int b = 0; b < batches; b++) begin
            if (b % 8 == 0) begin
                wait_drained();
                case (b / 8)
                    0: write_full_scale('0);
                    1: write_full_scale('1);
                    default: write_full_scale(FS_W'($urandom));
                endcase
            end
            build_random_batch();
            send_batch(1'($urandom_range(1, 0)));
        end
    endtask

    // words at full rate, no sender gaps
    task automatic test_back_to_back(input int batches);
        wait_drained();
        write_full_scale(FS_W'($urandom_range(4095, 2950)));
        for (int b = 0; b < batches; b++) begin
            if ($urandom_range(1, 0) == 0) build_batch_for(pick_band_target());
            else build_random_batch();
            send_batch(1'b0);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_first_batch_threshold();
        test_full_code_and_midbatch_scale();
        test_hysteresis_bands(64);
        test_random_batches(40);
        test_back_to_back(20);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_readings.size() != 0) begin
            $error("%0d expected readings never arrived", expected_readings.size());
            errors++;
        end

        $display("sent %0d sample words in %0d batches over %0d full-scale settings",
                 words_sent, batches_sent, scale_writes);
        $display("checked %0d level readings, %0d mismatches", readings_checked, errors);
        if (errors == 0) begin
            $display("battery_level_trimmed_mean_hysteresis_test: clean");
        end else begin
            $display("battery_level_trimmed_mean_hysteresis_test: errors");
        end
        $finish;
    end

endmodule
